// File: hw/rtl/bcd_pkg.sv
// ---------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants for the bounded circular deque.
// ---------------------------------------------------------------------------
package bcd_pkg;

    localparam int DEPTH_DEF = 16;   // ring entries
    localparam int CAP_RST   = 16;   // capacity after reset, before clamping
    localparam int CW        = 5;    // capacity / count width
    localparam int KW        = 3;    // operation kind width
    localparam int DW        = 32;   // element width
    localparam int AW        = 3;    // APB address width

    localparam logic [KW-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KW-1:0] KIND_INS_REAR  = 3'd1;
    localparam logic [KW-1:0] KIND_DEL_FRONT = 3'd2;
    localparam logic [KW-1:0] KIND_DEL_REAR  = 3'd3;
    localparam logic [KW-1:0] KIND_QUERY     = 3'd4;

    localparam logic [DW-1:0] EMPTY_MARK = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic latch_in;   // capture the incoming beat
        logic exec;       // apply the operation to pointers, count and ring
        logic load_out;   // move the snapshot into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_hold;   // output register holds a beat that is stalled
    } dp_status_t;

endpackage

// File: hw/rtl/bcd_ctrl.sv
// ---------------------------------------------------------------------------
// bcd_ctrl
// Sequencer: accept, execute, ring read, result load.
// ---------------------------------------------------------------------------
module bcd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bcd_pkg::dp_status_t status,
    output bcd_pkg::ctrl_cmd_t  cmd
);
    import bcd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!status.out_hold)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/bcd_dpath.sv
// ---------------------------------------------------------------------------
// bcd_dpath
// Ring memory, head/tail pointers, count, capacity and output register.
// ---------------------------------------------------------------------------
module bcd_dpath #(
    parameter int DEPTH = bcd_pkg::DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bcd_pkg::ctrl_cmd_t           cmd,
    output bcd_pkg::dp_status_t          status,
    input  logic                         cfg_we,
    input  logic [bcd_pkg::CW-1:0]       cfg_data,
    output logic [bcd_pkg::CW-1:0]       capacity,
    input  logic [bcd_pkg::KW-1:0]       kind,
    input  logic signed [bcd_pkg::DW-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         accepted,
    output logic signed [bcd_pkg::DW-1:0] front_value,
    output logic signed [bcd_pkg::DW-1:0] rear_value,
    output logic                         is_empty,
    output logic                         is_full,
    output logic [bcd_pkg::CW-1:0]       occupancy
);
    import bcd_pkg::*;

    localparam int IW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW       = ((IW > CW) ? IW : CW) + 1;
    localparam int CAP_INIT = (DEPTH < CAP_RST) ? DEPTH : CAP_RST;

    logic [DW-1:0]  ring_mem [DEPTH];
    logic [DW-1:0]  rd_front_reg;
    logic [DW-1:0]  rd_rear_reg;

    logic [KW-1:0]  kind_reg;
    logic [DW-1:0]  value_reg;
    logic [CW-1:0]  cap_reg;
    logic [CW-1:0]  cap_next;
    logic [IW-1:0]  head_reg;
    logic [IW-1:0]  head_next;
    logic [IW-1:0]  tail_reg;
    logic [IW-1:0]  tail_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           ok_reg;
    logic           ok_next;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic           full;
    logic           empty;

    logic           out_valid_reg;
    logic           accepted_reg;
    logic [DW-1:0]  front_reg;
    logic [DW-1:0]  rear_reg;
    logic           empty_reg;
    logic           full_reg;
    logic [CW-1:0]  occ_reg;

    function automatic logic [IW-1:0] step_up(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
        logic [IW-1:0] r;
        if (PW'(idx) + PW'(1) >= PW'(cap))
        begin
            r = '0;
        end
        else
        begin
            r = idx + IW'(1);
        end
        return r;
    endfunction

    function automatic logic [IW-1:0] step_down(input logic [IW-1:0] idx,
                                                input logic [CW-1:0] cap);
        logic [IW-1:0] r;
        if (idx == '0)
        begin
            r = IW'(cap - CW'(1));
        end
        else
        begin
            r = idx - IW'(1);
        end
        return r;
    endfunction

    // Written values of 0 act as 1, values beyond the ring act as DEPTH.
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            cap_next = CW'(1);
        end
        else if (int'(cfg_data) > DEPTH)
        begin
            cap_next = CW'(DEPTH);
        end
        else
        begin
            cap_next = cfg_data;
        end
    end

    assign full  = (count_reg >= cap_reg);
    assign empty = (count_reg == '0);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ok_next    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = head_reg;
        unique case (kind_reg)
            KIND_INS_FRONT:
            begin
                if (!full)
                begin
                    head_next  = step_down(head_reg, cap_reg);
                    mem_we     = 1'b1;
                    mem_waddr  = head_next;
                    count_next = count_reg + CW'(1);
                    ok_next    = 1'b1;
                end
            end
            KIND_INS_REAR:
            begin
                if (!full)
                begin
                    tail_next  = step_up(tail_reg, cap_reg);
                    mem_we     = 1'b1;
                    mem_waddr  = tail_next;
                    count_next = count_reg + CW'(1);
                    ok_next    = 1'b1;
                end
            end
            KIND_DEL_FRONT:
            begin
                if (!empty)
                begin
                    head_next  = step_up(head_reg, cap_reg);
                    count_next = count_reg - CW'(1);
                    ok_next    = 1'b1;
                end
            end
            KIND_DEL_REAR:
            begin
                if (!empty)
                begin
                    tail_next  = step_down(tail_reg, cap_reg);
                    count_next = count_reg - CW'(1);
                    ok_next    = 1'b1;
                end
            end
            KIND_QUERY:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;   // unused kinds are refused
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CW'(CAP_INIT);
            head_reg  <= '0;
            tail_reg  <= IW'(CAP_INIT - 1);
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg   <= cap_next;
            head_reg  <= '0;
            tail_reg  <= IW'(cap_next - CW'(1));
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg  <= kind;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            ok_reg <= ok_next;
        end
    end

    // Ring: one write port, two registered read ports at head and tail.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            ring_mem[mem_waddr] <= value_reg;
        end
        rd_front_reg <= ring_mem[head_reg];
        rd_rear_reg  <= ring_mem[tail_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            accepted_reg <= ok_reg;
            front_reg    <= empty ? EMPTY_MARK : rd_front_reg;
            rear_reg     <= empty ? EMPTY_MARK : rd_rear_reg;
            empty_reg    <= empty;
            full_reg     <= full;
            occ_reg      <= count_reg;
        end
    end

    assign status.out_hold = out_valid_reg && out_stall;

    assign capacity    = cap_reg;
    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign front_value = front_reg;
    assign rear_value  = rear_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;
    assign occupancy   = occ_reg;

endmodule

// File: hw/rtl/bounded_circular_deque.sv
// ---------------------------------------------------------------------------
// bounded_circular_deque
// Double-ended queue of 32-bit elements held in a ring of up to DEPTH entries.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall, kind, value) takes one operation per
// beat: insert front, insert rear, delete front, delete rear or query.
// Output channel (out_valid / out_stall) returns one result beat per input
// beat: accepted flag, front and rear elements (-1 when empty), empty, full
// and occupancy after the operation.
// Sequence: after an operation is accepted, the sequencer passes through
// execute, the registered read of the ring memory at head and tail, and the
// load of the output register, where out_valid rises; a new beat is taken
// only after the previous operation has loaded its result.
// A stalled result holds in the output register while the next operation is
// accepted and executed; that operation waits in its load step until the
// output register is free.
// Capacity sits at APB byte address 0; writing it (0 acts as 1, values above
// DEPTH act as DEPTH) empties the deque. Write it only while idle.
// Reset: capacity min(16, DEPTH), deque empty, no result pending.
// ---------------------------------------------------------------------------
module bounded_circular_deque #(
    parameter int DEPTH = bcd_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcd_pkg::AW-1:0]        paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bcd_pkg::KW-1:0]        kind,
    input  logic signed [bcd_pkg::DW-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic signed [bcd_pkg::DW-1:0] front_value,
    output logic signed [bcd_pkg::DW-1:0] rear_value,
    output logic                          is_empty,
    output logic                          is_full,
    output logic [bcd_pkg::CW-1:0]        occupancy
);
    import bcd_pkg::*;

    ctrl_cmd_t   cmd;
    dp_status_t  status;
    logic        cfg_we;
    logic        cap_sel;
    logic [CW-1:0] capacity;

    // paddr[2] set means an address beyond the capacity register
    assign cap_sel = !paddr[2];
    assign cfg_we  = psel && penable && pwrite && cap_sel;
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? 32'(capacity) : 32'd0;

    bcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bcd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_data    (pwdata[CW-1:0]),
        .capacity    (capacity),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .front_value (front_value),
        .rear_value  (rear_value),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .occupancy   (occupancy)
    );

endmodule
